### sv/sha384_pkg.sv
package sha384_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned DigestWords = 6;

  typedef logic [WordW-1:0] word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic store_word;   // write the accepted word into the block buffer
    logic init_vars;    // load working variables from the chaining words
    logic do_round;     // run one compression round
    logic add_chain;    // fold working variables into the chaining words
    logic pad_tail;     // write the 0x80 marker and clear the rest
    logic clear_low;    // clear words 0..13 for a second final block
    logic put_length;   // write the bit length into words 14 and 15
    logic restart;      // reload initial hash, clear counters
    logic shift_digest; // move the next digest word forward
  } sha_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic block_full;   // buffer reaches 128 bytes with this word
    logic is_final;     // accepted word ends the message
    logic pad_two;      // tail needs a second block
    logic last_round;   // round 79 is running
  } sha_sts_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t round_const(input logic [6:0] idx);
    word_t k;
    case (idx)
      7'd0: k = 64'h428A2F98D728AE22; 7'd1: k = 64'h7137449123EF65CD;
      7'd2: k = 64'hB5C0FBCFEC4D3B2F; 7'd3: k = 64'hE9B5DBA58189DBBC;
      7'd4: k = 64'h3956C25BF348B538; 7'd5: k = 64'h59F111F1B605D019;
      7'd6: k = 64'h923F82A4AF194F9B; 7'd7: k = 64'hAB1C5ED5DA6D8118;
      7'd8: k = 64'hD807AA98A3030242; 7'd9: k = 64'h12835B0145706FBE;
      7'd10: k = 64'h243185BE4EE4B28C; 7'd11: k = 64'h550C7DC3D5FFB4E2;
      7'd12: k = 64'h72BE5D74F27B896F; 7'd13: k = 64'h80DEB1FE3B1696B1;
      7'd14: k = 64'h9BDC06A725C71235; 7'd15: k = 64'hC19BF174CF692694;
      7'd16: k = 64'hE49B69C19EF14AD2; 7'd17: k = 64'hEFBE4786384F25E3;
      7'd18: k = 64'h0FC19DC68B8CD5B5; 7'd19: k = 64'h240CA1CC77AC9C65;
      7'd20: k = 64'h2DE92C6F592B0275; 7'd21: k = 64'h4A7484AA6EA6E483;
      7'd22: k = 64'h5CB0A9DCBD41FBD4; 7'd23: k = 64'h76F988DA831153B5;
      7'd24: k = 64'h983E5152EE66DFAB; 7'd25: k = 64'hA831C66D2DB43210;
      7'd26: k = 64'hB00327C898FB213F; 7'd27: k = 64'hBF597FC7BEEF0EE4;
      7'd28: k = 64'hC6E00BF33DA88FC2; 7'd29: k = 64'hD5A79147930AA725;
      7'd30: k = 64'h06CA6351E003826F; 7'd31: k = 64'h142929670A0E6E70;
      7'd32: k = 64'h27B70A8546D22FFC; 7'd33: k = 64'h2E1B21385C26C926;
      7'd34: k = 64'h4D2C6DFC5AC42AED; 7'd35: k = 64'h53380D139D95B3DF;
      7'd36: k = 64'h650A73548BAF63DE; 7'd37: k = 64'h766A0ABB3C77B2A8;
      7'd38: k = 64'h81C2C92E47EDAEE6; 7'd39: k = 64'h92722C851482353B;
      7'd40: k = 64'hA2BFE8A14CF10364; 7'd41: k = 64'hA81A664BBC423001;
      7'd42: k = 64'hC24B8B70D0F89791; 7'd43: k = 64'hC76C51A30654BE30;
      7'd44: k = 64'hD192E819D6EF5218; 7'd45: k = 64'hD69906245565A910;
      7'd46: k = 64'hF40E35855771202A; 7'd47: k = 64'h106AA07032BBD1B8;
      7'd48: k = 64'h19A4C116B8D2D0C8; 7'd49: k = 64'h1E376C085141AB53;
      7'd50: k = 64'h2748774CDF8EEB99; 7'd51: k = 64'h34B0BCB5E19B48A8;
      7'd52: k = 64'h391C0CB3C5C95A63; 7'd53: k = 64'h4ED8AA4AE3418ACB;
      7'd54: k = 64'h5B9CCA4F7763E373; 7'd55: k = 64'h682E6FF3D6B2B8A3;
      7'd56: k = 64'h748F82EE5DEFB2FC; 7'd57: k = 64'h78A5636F43172F60;
      7'd58: k = 64'h84C87814A1F0AB72; 7'd59: k = 64'h8CC702081A6439EC;
      7'd60: k = 64'h90BEFFFA23631E28; 7'd61: k = 64'hA4506CEBDE82BDE9;
      7'd62: k = 64'hBEF9A3F7B2C67915; 7'd63: k = 64'hC67178F2E372532B;
      7'd64: k = 64'hCA273ECEEA26619C; 7'd65: k = 64'hD186B8C721C0C207;
      7'd66: k = 64'hEADA7DD6CDE0EB1E; 7'd67: k = 64'hF57D4F7FEE6ED178;
      7'd68: k = 64'h06F067AA72176FBA; 7'd69: k = 64'h0A637DC5A2C898A6;
      7'd70: k = 64'h113F9804BEF90DAE; 7'd71: k = 64'h1B710B35131C471B;
      7'd72: k = 64'h28DB77F523047D84; 7'd73: k = 64'h32CAAB7B40C72493;
      7'd74: k = 64'h3C9EBE0A15C9BEBC; 7'd75: k = 64'h431D67C49C100D4C;
      7'd76: k = 64'h4CC5D4BECB3E42B6; 7'd77: k = 64'h597F299CFC657E2A;
      7'd78: k = 64'h5FCB6FAB3AD6FAEC; 7'd79: k = 64'h6C44198C4A475817;
      default: k = '0;
    endcase
    round_const = k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 64'hCBBB9D5DC1059ED8; 3'd1: h = 64'h629A292A367CD507;
      3'd2: h = 64'h9159015A3070DD17; 3'd3: h = 64'h152FECD8F70E5939;
      3'd4: h = 64'h67332667FFC00B31; 3'd5: h = 64'h8EB44A8768581511;
      3'd6: h = 64'hDB0C2E0D64F98FA7; default: h = 64'h47B5481DBEFA4FA4;
    endcase
    init_hash = h;
  endfunction

endpackage

### sv/sha384_if.sv
interface sha384_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, data_word, valid_bytes, last_word, input ready);
  modport sink (input valid, data_word, valid_bytes, last_word, output ready);
endinterface

interface sha384_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface

### sv/sha384_ctrl.sv
module sha384_ctrl
  import sha384_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output logic     out_last_o,
  input  sha_sts_t sts_i,
  output sha_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_ROUND, S_ADD, S_PAD, S_INIT2, S_ROUND2, S_ADD2,
    S_CLR, S_LEN, S_INIT3, S_ROUND3, S_ADD3, S_OUT
  } state_e;

  state_e     state_q, state_d;
  logic       final_q, final_d;
  logic [2:0] cnt_q, cnt_d;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    final_d = final_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.store_word = 1'b1;
          final_d = sts_i.is_final;
          if (sts_i.block_full) state_d = S_INIT;
          else if (sts_i.is_final) state_d = S_PAD;
        end
      end
      S_INIT: begin
        cmd_o.init_vars = 1'b1;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.do_round = 1'b1;
        if (sts_i.last_round) state_d = S_ADD;
      end
      S_ADD: begin
        cmd_o.add_chain = 1'b1;
        state_d = final_q ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        cmd_o.pad_tail = 1'b1;
        state_d = sts_i.pad_two ? S_INIT2 : S_LEN;
      end
      S_INIT2: begin
        cmd_o.init_vars = 1'b1;
        state_d = S_ROUND2;
      end
      S_ROUND2: begin
        cmd_o.do_round = 1'b1;
        if (sts_i.last_round) state_d = S_ADD2;
      end
      S_ADD2: begin
        cmd_o.add_chain = 1'b1;
        state_d = S_CLR;
      end
      S_CLR: begin
        cmd_o.clear_low = 1'b1;
        state_d = S_LEN;
      end
      S_LEN: begin
        cmd_o.put_length = 1'b1;
        state_d = S_INIT3;
      end
      S_INIT3: begin
        cmd_o.init_vars = 1'b1;
        state_d = S_ROUND3;
      end
      S_ROUND3: begin
        cmd_o.do_round = 1'b1;
        if (sts_i.last_round) state_d = S_ADD3;
      end
      S_ADD3: begin
        cmd_o.add_chain = 1'b1;
        cnt_d = '0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          cmd_o.shift_digest = 1'b1;
          cnt_d = cnt_q + 3'd1;
          if (cnt_q == 3'(DigestWords - 1)) begin
            cmd_o.restart = 1'b1;
            final_d = 1'b0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_last_o  = (cnt_q == 3'(DigestWords - 1));

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      final_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### sv/sha384_dpath.sv
module sha384_dpath
  import sha384_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        last_word_i,
  input  sha_cmd_t    cmd_i,
  output sha_sts_t    sts_o,
  output logic [63:0] digest_word_o
);

  word_t         chain_q [8];
  word_t         vars_q  [8];
  word_t         sched_q [16];
  logic [127:0]  bytes_q;
  logic [6:0]    fill_q;
  logic [6:0]    round_q;

  logic [3:0]    nv;
  word_t         masked;
  logic [7:0]    fill_sum;
  logic [3:0]    wi;
  logic [2:0]    off;
  word_t         w_cur, w_new, t1, t2, s0, s1, keep, mark;
  logic [3:0]    j;

  // Clamp the byte count and clear trailing bytes
  always_comb begin
    nv = (valid_bytes_i > 4'd8) ? 4'd8 : valid_bytes_i;
    masked = (nv == 4'd0) ? '0 : (data_word_i & ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * nv)));
    fill_sum = {1'b0, fill_q} + {4'd0, nv};
  end

  assign sts_o.block_full = fill_sum[7];
  assign sts_o.is_final   = last_word_i || (nv != 4'd8);
  assign sts_o.pad_two    = (fill_q >= 7'd112);
  assign sts_o.last_round = (round_q == 7'd79);

  assign wi  = fill_q[6:3];
  assign off = fill_q[2:0];

  // Round function and schedule expansion
  always_comb begin
    j  = round_q[3:0];
    s1 = rotr(sched_q[j + 4'd14], 19) ^ rotr(sched_q[j + 4'd14], 61) ^ (sched_q[j + 4'd14] >> 6);
    s0 = rotr(sched_q[j + 4'd1], 1) ^ rotr(sched_q[j + 4'd1], 8) ^ (sched_q[j + 4'd1] >> 7);
    w_new = s1 + sched_q[j + 4'd9] + s0 + sched_q[j];
    w_cur = (round_q >= 7'd16) ? w_new : sched_q[j];
    t1 = vars_q[7] + (rotr(vars_q[4], 14) ^ rotr(vars_q[4], 18) ^ rotr(vars_q[4], 41))
       + ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6])) + round_const(round_q) + w_cur;
    t2 = (rotr(vars_q[0], 28) ^ rotr(vars_q[0], 34) ^ rotr(vars_q[0], 39))
       + ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
    keep = (off == 3'd0) ? '0 : (sched_q[wi] & ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * off)));
    mark = 64'h8000_0000_0000_0000 >> (8 * off);
  end

  // Block buffer and schedule
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_word) sched_q[wi] <= masked;
    if (cmd_i.do_round) sched_q[j] <= w_cur;
    if (cmd_i.pad_tail) begin
      for (int i = 0; i < 16; i++) begin
        if (4'(i) == wi) sched_q[i] <= keep | mark;
        else if (4'(i) > wi) sched_q[i] <= '0;
      end
    end
    if (cmd_i.clear_low) begin
      for (int i = 0; i < 14; i++) sched_q[i] <= '0;
    end
    if (cmd_i.put_length) begin
      sched_q[14] <= {bytes_q[124:64], bytes_q[63:61]};
      sched_q[15] <= {bytes_q[60:0], 3'b000};
    end
  end

  // Chaining words, working variables and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= init_hash(3'(i));
        vars_q[i]  <= '0;
      end
      bytes_q <= '0;
      fill_q  <= '0;
      round_q <= '0;
    end else begin
      if (cmd_i.store_word) begin
        bytes_q <= bytes_q + {124'd0, nv};
        fill_q  <= fill_sum[6:0];
      end
      if (cmd_i.init_vars) begin
        for (int i = 0; i < 8; i++) vars_q[i] <= chain_q[i];
        round_q <= '0;
      end
      if (cmd_i.do_round) begin
        vars_q[7] <= vars_q[6]; vars_q[6] <= vars_q[5]; vars_q[5] <= vars_q[4];
        vars_q[4] <= vars_q[3] + t1;
        vars_q[3] <= vars_q[2]; vars_q[2] <= vars_q[1]; vars_q[1] <= vars_q[0];
        vars_q[0] <= t1 + t2;
        round_q <= (round_q == 7'd79) ? 7'd0 : round_q + 7'd1;
      end
      if (cmd_i.add_chain) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + vars_q[i];
      end
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= init_hash(3'(i));
        bytes_q <= '0;
        fill_q  <= '0;
      end else if (cmd_i.shift_digest) begin
        for (int i = 0; i < 7; i++) chain_q[i] <= chain_q[i + 1];
        chain_q[7] <= chain_q[0];
      end
    end
  end

  assign digest_word_o = chain_q[0];

endmodule

### sv/sha384_hash_engine_core.sv
// SHA-384 engine. Message words (64-bit, big-endian, with a count of valid
// leading bytes and a last flag) are taken one per cycle while the 128-byte
// block buffer fills; the 16th word of a block starts an 80-round compression
// at one round per cycle, during which input stalls. A final word (last
// flag, or fewer than 8 valid bytes) pads the message, runs one or two more
// compressions, then presents the six digest words in order, the sixth
// flagged last, and reinitializes for the next message.
module sha384_hash_engine_core
  import sha384_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  sha384_in_if.sink    in_if,
  sha384_out_if.source out_if
);

  sha_cmd_t cmd;
  sha_sts_t sts;

  sha384_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_last_o  (out_if.digest_last),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sha384_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_word_i   (in_if.data_word),
    .valid_bytes_i (in_if.valid_bytes),
    .last_word_i   (in_if.last_word),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .digest_word_o (out_if.digest_word)
  );

endmodule

### sv/sha384_checker.sv
module sha384_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_last_i
);

  // Input and output never open together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_i && out_valid_i))
    else $error("input taken while digest pending");

  // After the last digest transaction the input reopens
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_last_i |=> in_ready_i)
    else $error("input not reopened after digest");

  // A stalled digest word stays valid and keeps its last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_last_i))
    else $error("digest dropped while stalled");

endmodule

bind sha384_hash_engine_core sha384_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .out_last_i  (out_if.digest_last)
);
